// ----- rtl/mwdds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwdds_pkg;

  // default sizes for the top-level parameters
  localparam int PHASE_BITS_DEF           = 32;
  localparam int SINE_TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF          = 16;

  // configuration register file
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int PHASE_INC_W = 32;
  localparam int AMP_W       = 16;
  localparam int WF_SEL_W    = 2;
  localparam int IN_TDATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM  = 2'd2;

  localparam logic [AMP_W-1:0] AMP_UNITY = 16'h8000;

  // Q1.15 rounding constant and shift after the gain multiply
  localparam int AMP_FRAC     = 15;
  localparam int AMP_ROUND    = 16384;

  typedef enum logic [WF_SEL_W-1:0] {
    WF_SINE     = 2'd0,
    WF_SQUARE   = 2'd1,
    WF_TRIANGLE = 2'd2,
    WF_SAW      = 2'd3
  } wf_sel_t;

  // 9th-order odd sine polynomial, Q30
  localparam longint POLY_C1 = 64'sd1686629713;
  localparam longint POLY_C3 = 64'sd693598668;
  localparam longint POLY_C5 = 64'sd85569306;
  localparam longint POLY_C7 = 64'sd5026995;
  localparam longint POLY_C9 = 64'sd172272;
  localparam longint Q30_ONE = 64'sd1073741824;

  // side information travelling alongside the sine table read
  typedef struct packed {
    logic use_sine;
    logic negate;
  } shape_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/mwdds_phase.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwdds_phase #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire logic                             load,
  input  wire logic                             restart,
  input  wire logic [mwdds_pkg::PHASE_INC_W-1:0] phase_inc,
  output logic      [PHASE_BITS-1:0]            phase_s1_r
);
  import mwdds_pkg::*;

  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] acc_nxt;
  logic [PHASE_BITS-1:0] phase_used;

  // restart clears the phase before the sample is taken from it
  assign phase_used = restart ? '0 : acc_r;
  assign acc_nxt    = phase_used + PHASE_BITS'(phase_inc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (accept) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      phase_s1_r <= phase_used;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwdds_sine_rom.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwdds_sine_rom #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS          = 16
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [SINE_TABLE_ADDR_BITS:0]   addr,
  output logic      [SAMPLE_BITS-2:0]          data_r
);
  import mwdds_pkg::*;

  localparam int     DEPTH = (1 << SINE_TABLE_ADDR_BITS) + 1;
  localparam longint PEAK  = (64'sd1 << (SAMPLE_BITS - 1)) - 64'sd1;

  typedef logic [SAMPLE_BITS-2:0] rom_t [0:DEPTH-1];

  // quarter sine, round(PEAK * sin(pi/2 * i / 2^A)), evaluated at elaboration
  function automatic rom_t build_quarter();
    rom_t   tbl;
    longint x;
    longint x2;
    longint acc;
    longint s;
    for (int i = 0; i < DEPTH; i++) begin
      x   = longint'(i) <<< (30 - SINE_TABLE_ADDR_BITS);
      x2  = (x * x) >>> 30;
      acc = POLY_C9;
      acc = ((acc * x2) >>> 30) - POLY_C7;
      acc = ((acc * x2) >>> 30) + POLY_C5;
      acc = ((acc * x2) >>> 30) - POLY_C3;
      acc = ((acc * x2) >>> 30) + POLY_C1;
      s   = (acc * x) >>> 30;
      if (s < 0) s = 0;
      if (s > Q30_ONE) s = Q30_ONE;
      s = (s * PEAK + (Q30_ONE >>> 1)) >>> 30;
      if (s > PEAK) s = PEAK;
      tbl[i] = s[SAMPLE_BITS-2:0];
    end
    return tbl;
  endfunction

  localparam rom_t QUARTER = build_quarter();

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= QUARTER[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwdds_shape.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwdds_shape #(
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS          = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [PHASE_BITS-1:0]         phase,
  input  wire mwdds_pkg::wf_sel_t            waveform,
  output logic      [SINE_TABLE_ADDR_BITS:0] rom_addr,
  output mwdds_pkg::shape_ctl_t              ctl_r,
  output logic signed [SAMPLE_BITS:0]        raw_r
);
  import mwdds_pkg::*;

  localparam int A = SINE_TABLE_ADDR_BITS;
  localparam logic [A:0] QTR_LEN = (A+1)'(1) << A;
  localparam logic signed [SAMPLE_BITS+1:0] FULL = (SAMPLE_BITS+2)'(1) <<< (SAMPLE_BITS - 1);

  logic [1:0]                      quad;
  logic [A-1:0]                    idx;
  logic signed [SAMPLE_BITS-1:0]   saw;
  logic signed [SAMPLE_BITS+1:0]   saw_x;
  logic signed [SAMPLE_BITS+1:0]   mag;
  logic signed [SAMPLE_BITS+1:0]   tri_x;
  logic signed [SAMPLE_BITS+1:0]   sq_x;
  logic signed [SAMPLE_BITS:0]     raw_nxt;
  shape_ctl_t                      ctl_nxt;

  assign quad = phase[PHASE_BITS-1 -: 2];
  assign idx  = phase[PHASE_BITS-3 -: A];

  // second and fourth quadrants read the table mirrored
  assign rom_addr = quad[0] ? (QTR_LEN - {1'b0, idx}) : {1'b0, idx};

  // sawtooth: phase as signed, floored to the sample width
  generate
    if (PHASE_BITS >= SAMPLE_BITS) begin : g_saw_cut
      assign saw = $signed(phase[PHASE_BITS-1 -: SAMPLE_BITS]);
    end else begin : g_saw_pad
      assign saw = $signed({phase, {(SAMPLE_BITS-PHASE_BITS){1'b0}}});
    end
  endgenerate

  assign saw_x = (SAMPLE_BITS+2)'(saw);
  assign mag   = saw[SAMPLE_BITS-1] ? -saw_x : saw_x;
  assign tri_x = (mag <<< 1) - FULL;
  assign sq_x  = quad[1] ? -FULL : FULL;

  always_comb begin
    raw_nxt = '0;
    unique case (waveform)
      WF_SINE:     raw_nxt = '0;
      WF_SQUARE:   raw_nxt = sq_x[SAMPLE_BITS:0];
      WF_TRIANGLE: raw_nxt = tri_x[SAMPLE_BITS:0];
      WF_SAW:      raw_nxt = saw_x[SAMPLE_BITS:0];
      default:     raw_nxt = '0;
    endcase
    ctl_nxt.use_sine = (waveform == WF_SINE);
    ctl_nxt.negate   = quad[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw_r <= raw_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwdds_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwdds_scale #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire mwdds_pkg::shape_ctl_t        ctl,
  input  wire logic signed [SAMPLE_BITS:0]  raw,
  input  wire logic [SAMPLE_BITS-2:0]       rom_data,
  input  wire logic [mwdds_pkg::AMP_W-1:0]  amplitude,
  output logic      [SAMPLE_BITS-1:0]       sample_r
);
  import mwdds_pkg::*;

  localparam int PW = SAMPLE_BITS + AMP_W + 2;
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (SAMPLE_BITS - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -(PW'(1) <<< (SAMPLE_BITS - 1));
  localparam logic signed [PW-1:0] RND    = PW'(AMP_ROUND);

  logic signed [SAMPLE_BITS:0] sine_x;
  logic signed [SAMPLE_BITS:0] w;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        scaled;
  logic signed [PW-1:0]        sat;

  assign sine_x = $signed({2'b00, rom_data});
  assign w      = ctl.use_sine ? (ctl.negate ? -sine_x : sine_x) : raw;
  assign prod   = PW'(w) * PW'($signed({1'b0, amplitude}));
  assign scaled = (prod + RND) >>> AMP_FRAC;

  always_comb begin
    priority if (scaled > SAT_HI) begin
      sat = SAT_HI;
    end else if (scaled < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sat[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multi_waveform_dds_generator_top.sv -----
// An accepted transaction reaches out_tvalid through the phase register, the
// registered sine table read and the gain/saturate output register.
// Throughput: one sample per clock; each stage holds only while the one after it is full.
// Reset (rst_n low, synchronous): phase accumulator and pipeline valids cleared,
// phase increment 0, amplitude unity (0x8000), waveform sine.
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_dds_generator_top #(
  parameter int PHASE_BITS           = mwdds_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = mwdds_pkg::SINE_TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS          = mwdds_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [mwdds_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] restart
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,  // [SAMPLE_BITS-1:0] sample
  input  wire logic                                cfg_we,
  input  wire logic [mwdds_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [mwdds_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mwdds_pkg::*;

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  logic [PHASE_INC_W-1:0] phase_inc_r;
  logic [AMP_W-1:0]       amplitude_r;
  wf_sel_t                waveform_r;

  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic accept;

  logic [PHASE_BITS-1:0]           phase_s1;
  logic [SINE_TABLE_ADDR_BITS:0]   rom_addr;
  logic [SAMPLE_BITS-2:0]          rom_data;
  shape_ctl_t                      ctl_s2;
  logic signed [SAMPLE_BITS:0]     raw_s2;
  logic [SAMPLE_BITS-1:0]          sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      amplitude_r <= AMP_UNITY;
      waveform_r  <= WF_SINE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_INC: phase_inc_r <= cfg_wdata[PHASE_INC_W-1:0];
        REG_AMPLITUDE: amplitude_r <= cfg_wdata[AMP_W-1:0];
        REG_WAVEFORM:  waveform_r  <= wf_sel_t'(cfg_wdata[WF_SEL_W-1:0]);
        default: ;
      endcase
    end
  end

  // each stage moves on when empty or when the stage after it moves
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  mwdds_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .load       (rdy1),
    .restart    (in_tdata[0]),
    .phase_inc  (phase_inc_r),
    .phase_s1_r (phase_s1)
  );

  mwdds_shape #(
    .PHASE_BITS           (PHASE_BITS),
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .SAMPLE_BITS          (SAMPLE_BITS)
  ) u_shape (
    .clk      (clk),
    .en       (rdy2),
    .phase    (phase_s1),
    .waveform (waveform_r),
    .rom_addr (rom_addr),
    .ctl_r    (ctl_s2),
    .raw_r    (raw_s2)
  );

  mwdds_sine_rom #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .SAMPLE_BITS          (SAMPLE_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .en     (rdy2),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  mwdds_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk       (clk),
    .en        (rdy3),
    .ctl       (ctl_s2),
    .raw       (raw_s2),
    .rom_data  (rom_data),
    .amplitude (amplitude_r),
    .sample_r  (sample)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = OUT_W'(sample);

  // a restart transaction leaves a zero phase in the first stage
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tdata[0] |=> phase_s1 == '0)
    else $error("restart did not clear the phase");

  // table stage keeps its contents while the output stage is blocked
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(ctl_s2) && $stable(raw_s2) && $stable(rom_data))
    else $error("table stage changed while stalled");

  // a full pipe with a stalled output takes no new transaction
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && !out_tready |-> !in_tready)
    else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mwdds_pkg::*;

  localparam int    FS         = 32768;  // full scale of a Q1.15 sample
  localparam int    QTR        = 1024;   // quarter table length
  localparam int    STALL_LIMIT = 2000;
  localparam int    RANDOM_ITEMS = 1500;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  multi_waveform_dds_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state
  longint                  quarter_sine [0:QTR];
  logic [31:0]             phase_acc;
  logic [PHASE_INC_W-1:0]  inc_reg;
  logic [AMP_W-1:0]        amp_reg;
  wf_sel_t                 wf_reg;

  bit                      restart_queue [$];
  logic signed [15:0]      expected_samples [$];
  bit                      in_taken;
  bit                      calm;
  int                      in_gap;
  int                      stall_left;
  int                      errors;
  int                      idle_cycles;
  int                      sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic void build_sine_table();
    longint x, x2, acc, s;
    for (int i = 0; i <= QTR; i++) begin
      x   = longint'(i) <<< 20;
      x2  = q30_mul(x, x);
      acc = POLY_C9;
      acc = q30_mul(acc, x2) - POLY_C7;
      acc = q30_mul(acc, x2) + POLY_C5;
      acc = q30_mul(acc, x2) - POLY_C3;
      acc = q30_mul(acc, x2) + POLY_C1;
      s   = q30_mul(acc, x);
      if (s < 0) s = 0;
      if (s > Q30_ONE) s = Q30_ONE;
      s = (s * (FS - 1) + (Q30_ONE >>> 1)) >>> 30;
      if (s > FS - 1) s = FS - 1;
      quarter_sine[i] = s;
    end
  endfunction

  // next sample of the generator; advances the phase
  function automatic logic signed [15:0] next_sample(input bit restart);
    longint     w, v, saw;
    int         idx;
    logic [1:0] quad;
    if (restart) phase_acc = '0;
    quad = phase_acc[31:30];
    idx  = int'(phase_acc[29:20]);
    case (wf_reg)
      WF_SINE: begin
        case (quad)
          2'd0:    w = quarter_sine[idx];
          2'd1:    w = quarter_sine[QTR - idx];
          2'd2:    w = -quarter_sine[idx];
          default: w = -quarter_sine[QTR - idx];
        endcase
      end
      WF_SQUARE: w = quad[1] ? -FS : FS;
      default: begin
        saw = longint'($signed(phase_acc)) >>> 16;
        if (wf_reg == WF_SAW) begin
          w = saw;
        end else begin
          if (saw < 0) saw = -saw;
          w = 2 * saw - FS;
        end
      end
    endcase
    v = (w * longint'(amp_reg) + AMP_ROUND) >>> AMP_FRAC;
    if (v > FS - 1) v = FS - 1;
    if (v < -FS) v = -FS;
    phase_acc = phase_acc + inc_reg;
    return v[15:0];
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // source side
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (restart_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'(restart_queue.pop_front());
        in_gap    = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // sink side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // prediction on input transactions, checking on output transactions
  always @(posedge clk) begin
    logic signed [15:0] want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_samples.push_back(next_sample(in_tdata[0]));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected sample %0d", $realtime, $signed(out_tdata));
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] sample mismatch: expected %0d got %0d (wf %s amp %h)",
                     $realtime, want, $signed(out_tdata), wf_reg.name(), amp_reg);
        end
      end
    end
  end

  // watchdog: nothing moving for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_PHASE_INC: inc_reg = val[PHASE_INC_W-1:0];
      REG_AMPLITUDE: amp_reg = val[AMP_W-1:0];
      REG_WAVEFORM:  wf_reg  = wf_sel_t'(val[WF_SEL_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (restart_queue.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] inc, input logic [31:0] amp,
                           input logic [31:0] wf, input int n, input int restart_pct,
                           input bit lead_restart);
    write_reg(REG_PHASE_INC, inc);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_WAVEFORM, wf);
    for (int k = 0; k < n; k++)
      restart_queue.push_back((k == 0 && lead_restart) ||
                              ($urandom_range(0, 99) < restart_pct));
    sent += n;
    wait_idle();
  endtask

  initial begin
    logic [31:0] inc, amp;
    int          r;
    build_sine_table();
    phase_acc = '0;
    inc_reg   = '0;
    amp_reg   = AMP_UNITY;
    wf_reg    = WF_SINE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: phase 0, no increment, unity sine
    restart_queue.push_back(1'b0);
    restart_queue.push_back(1'b1);
    wait_idle();

    // quarter-turn steps hit every sine quadrant and both peaks
    run_phase(32'h4000_0000, 32'h0000_8000, WF_SINE, 5, 0, 1'b1);
    // gain above unity saturates
    run_phase(32'h4000_0000, 32'h0000_FFFF, WF_SQUARE, 3, 0, 1'b1);
    run_phase(32'h4000_0000, 32'h0000_0000, WF_TRIANGLE, 2, 0, 1'b0);
    // triangle peak at half turn saturates; upper bits of the write dropped
    run_phase(32'h8000_0000, 32'hFFFF_8000, WF_TRIANGLE, 3, 0, 1'b1);
    // saw just below zero phase
    run_phase(32'hFFFF_FFFF, 32'h0000_8000, WF_SAW, 4, 0, 1'b1);
    run_phase(32'h7FFF_FFFF, 32'h0000_4000, 32'hFFFF_FFFF, 4, 50, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r == 0)      inc = 32'h0;
      else if (r == 1) inc = 32'hFFFF_FFFF;
      else if (r == 2) inc = 32'h8000_0000;
      else if (r < 6)  inc = $urandom_range(1, 1 << 24);
      else             inc = $urandom();
      r = $urandom_range(0, 9);
      if (r == 0)      amp = 32'h0;
      else if (r == 1) amp = 32'(AMP_UNITY);
      else if (r == 2) amp = 32'h0000_FFFF;
      else if (r < 7)  amp = $urandom_range(0, 32768);
      else             amp = $urandom();
      run_phase(inc, amp, $urandom(), $urandom_range(10, 80), $urandom_range(0, 10),
                $urandom_range(0, 1));
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
